/* rtl/core/imr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imr_pkg
// Shared types and constants for the minimum resource count block.
// ----------------------------------------------------------------------------
package imr_pkg;

  localparam int MAX_INTERVALS_DEF = 1024;
  localparam int TIME_W            = 32;
  localparam int COUNT_W           = 11;

  // one interval in
  typedef struct packed {
    logic signed [TIME_W-1:0] start_time;
    logic signed [TIME_W-1:0] end_time;
    logic                     last_interval;
  } item_t;

  // one result out
  typedef struct packed {
    logic [COUNT_W-1:0] resource_count;
    logic               overflowed;
  } result_t;

  // heads of the two runs being merged
  typedef struct packed {
    logic signed [TIME_W-1:0] left_head;
    logic signed [TIME_W-1:0] right_head;
  } heads_t;

  // merge decision
  typedef struct packed {
    logic any;
    logic take_left;
  } pick_t;

endpackage

/* rtl/core/imr_merge_pick.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imr_merge_pick
// Chooses the next element of a two-run merge from the run heads and bounds.
// ----------------------------------------------------------------------------
module imr_merge_pick #(
  parameter int CW = 8
) (
  input  logic [CW-1:0]       li,
  input  logic [CW-1:0]       le,
  input  logic [CW-1:0]       ri,
  input  logic [CW-1:0]       re,
  input  imr_pkg::heads_t     heads,
  output imr_pkg::pick_t      pick
);
  import imr_pkg::*;

  logic lvalid;
  logic rvalid;

  // left wins on a tie or when the right run is used up
  always_comb begin
    lvalid         = (li < le);
    rvalid         = (ri < re);
    pick.any       = lvalid | rvalid;
    pick.take_left = lvalid & (~rvalid | (heads.left_head <= heads.right_head));
  end

endmodule

/* rtl/core/interval_min_resources.sv */
`timescale 1ns / 1ps
// A non-final interval is written to the stores when accepted. The final one starts a
// bottom-up merge sort of the start store, then of the end store, each over
// ceil(log2 n) passes of run merges for n intervals, then a sweep over them.
// New intervals are stalled until the result for the set has been issued.
// Throughput is set by the single read port of each store.
// Reset clears control state only; the stores need no clearing pass.
// ----------------------------------------------------------------------------
// interval_min_resources
// Minimum number of resources for a set of intervals, via sorted stores.
// ----------------------------------------------------------------------------
module interval_min_resources #(
  parameter int MAX_INTERVALS = imr_pkg::MAX_INTERVALS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  imr_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output imr_pkg::result_t result
);
  import imr_pkg::*;

  localparam int AW    = $clog2(MAX_INTERVALS);
  localparam int CW    = AW + 3;
  localparam int KW    = (CW > COUNT_W) ? CW : COUNT_W;
  localparam int DEPTH = 2 << AW;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_RUN   = 10'b0000000010,
    ST_RDL   = 10'b0000000100,
    ST_RDR   = 10'b0000001000,
    ST_CAP   = 10'b0000010000,
    ST_MRG   = 10'b0000100000,
    ST_FET   = 10'b0001000000,
    ST_SWRD  = 10'b0010000000,
    ST_SWCMP = 10'b0100000000,
    ST_DONE  = 10'b1000000000
  } state_t;

  state_t state;

  logic signed [TIME_W-1:0] st_mem [DEPTH];
  logic signed [TIME_W-1:0] en_mem [DEPTH];
  logic signed [TIME_W-1:0] st_rd, en_rd, rd;

  logic [CW-1:0] loaded, loaded_next, n;
  logic          ovf, ovf_next;
  logic          field, bank, took_left;
  logic [CW-1:0] w, base, li, le, ri, re, oi;
  logic [CW-1:0] i, j;
  logic [KW-1:0] count;
  logic signed [TIME_W-1:0] lh, rh;

  logic              st_we, en_we;
  logic [AW:0]       st_waddr, en_waddr, st_raddr, en_raddr;
  logic signed [TIME_W-1:0] st_wdata, en_wdata, take_val;
  logic              accept;
  logic [CW-1:0]     li_inc, ri_inc, w2, run_mid, run_end;
  heads_t            heads;
  pick_t             pick;

  function automatic logic [CW-1:0] min_cw(input logic [CW-1:0] a, input logic [CW-1:0] b);
    min_cw = (a < b) ? a : b;
  endfunction

  imr_merge_pick #(.CW(CW)) u_pick (
    .li(li), .le(le), .ri(ri), .re(re), .heads(heads), .pick(pick)
  );

  // input side and load bookkeeping
  always_comb begin
    item_stall  = (state != ST_IDLE);
    accept      = item_valid & ~item_stall;
    loaded_next = loaded;
    ovf_next    = ovf;
    if (loaded < CW'(MAX_INTERVALS)) begin
      loaded_next = loaded + 1'b1;
    end else begin
      ovf_next = 1'b1;
    end
  end

  // merge helpers
  always_comb begin
    heads.left_head  = lh;
    heads.right_head = rh;
    rd       = field ? en_rd : st_rd;
    take_val = pick.take_left ? lh : rh;
    li_inc   = li + 1'b1;
    ri_inc   = ri + 1'b1;
    w2       = w << 1;
    run_mid  = min_cw(base + w, n);
    run_end  = min_cw(base + w2, n);
  end

  // memory port selection
  always_comb begin
    st_we    = 1'b0;
    en_we    = 1'b0;
    st_waddr = {1'b0, loaded[AW-1:0]};
    en_waddr = {1'b0, loaded[AW-1:0]};
    st_wdata = item.start_time;
    en_wdata = item.end_time;
    st_raddr = {bank, li[AW-1:0]};
    en_raddr = {bank, li[AW-1:0]};
    case (state)
      ST_IDLE: begin
        st_we = accept & (loaded < CW'(MAX_INTERVALS));
        en_we = st_we;
      end
      ST_RDR: begin
        st_raddr = {bank, ri[AW-1:0]};
        en_raddr = {bank, ri[AW-1:0]};
      end
      ST_MRG: begin
        st_we    = pick.any & ~field;
        en_we    = pick.any & field;
        st_waddr = {~bank, oi[AW-1:0]};
        en_waddr = {~bank, oi[AW-1:0]};
        st_wdata = take_val;
        en_wdata = take_val;
        st_raddr = pick.take_left ? {bank, li_inc[AW-1:0]} : {bank, ri_inc[AW-1:0]};
        en_raddr = st_raddr;
      end
      ST_SWRD: begin
        st_raddr = {bank, i[AW-1:0]};
        en_raddr = {bank, j[AW-1:0]};
      end
      default: begin
      end
    endcase
  end

  // stores
  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[st_waddr] <= st_wdata;
    end
    if (en_we) begin
      en_mem[en_waddr] <= en_wdata;
    end
    st_rd <= st_mem[st_raddr];
    en_rd <= en_mem[en_raddr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      loaded       <= '0;
      ovf          <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      // the done state handles its own result transfer
      if (result_valid & ~result_stall & (state != ST_DONE)) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            loaded <= loaded_next;
            ovf    <= ovf_next;
            if (item.last_interval) begin
              n     <= loaded_next;
              field <= 1'b0;
              bank  <= 1'b0;
              w     <= CW'(1);
              base  <= '0;
              i     <= '0;
              j     <= '0;
              count <= '0;
              state <= (loaded_next == CW'(1)) ? ST_SWRD : ST_RUN;
            end
          end
        end
        ST_RUN: begin
          if (base >= n) begin
            bank <= ~bank;
            w    <= w2;
            base <= '0;
            if (w2 >= n) begin
              if (!field) begin
                field <= 1'b1;
                bank  <= 1'b0;
                w     <= CW'(1);
              end else begin
                state <= ST_SWRD;
              end
            end
          end else begin
            li    <= base;
            le    <= run_mid;
            ri    <= run_mid;
            re    <= run_end;
            oi    <= base;
            base  <= base + w2;
            state <= ST_RDL;
          end
        end
        ST_RDL: state <= ST_RDR;
        ST_RDR: begin
          lh    <= rd;
          state <= ST_CAP;
        end
        ST_CAP: begin
          rh    <= rd;
          state <= ST_MRG;
        end
        ST_MRG: begin
          if (pick.any) begin
            oi        <= oi + 1'b1;
            took_left <= pick.take_left;
            if (pick.take_left) begin
              li <= li_inc;
            end else begin
              ri <= ri_inc;
            end
            state <= ST_FET;
          end else begin
            state <= ST_RUN;
          end
        end
        ST_FET: begin
          if (took_left) begin
            lh <= rd;
          end else begin
            rh <= rd;
          end
          state <= ST_MRG;
        end
        ST_SWRD: state <= ST_SWCMP;
        ST_SWCMP: begin
          if (st_rd >= en_rd) begin
            j <= j + 1'b1;
          end else begin
            count <= count + 1'b1;
          end
          i     <= i + 1'b1;
          state <= (i + 1'b1 == n) ? ST_DONE : ST_SWRD;
        end
        ST_DONE: begin
          if (!result_valid || !result_stall) begin
            result_valid          <= 1'b1;
            result.resource_count <= count[COUNT_W-1:0];
            result.overflowed     <= ovf;
            loaded                <= '0;
            ovf                   <= 1'b0;
            state                 <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // merge cursors stay inside their runs
  a_run_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MRG) |-> (li <= le && ri <= re))
    else $error("merge cursor beyond run end");

  // sweep end pointer never passes start pointer
  a_sweep_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SWCMP) |-> (j <= i))
    else $error("sweep end pointer ahead of start pointer");

  // a taken result is only followed by a new one from the done state
  a_result_once: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_stall && state != ST_DONE) |=> !result_valid)
    else $error("result repeated");

  // store fill never exceeds capacity
  a_fill: assert property (@(posedge clk) disable iff (rst)
    loaded <= CW'(MAX_INTERVALS))
    else $error("store fill beyond capacity");
`endif

endmodule

/* test/interval_min_resources_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_min_resources_test
// Sends sets of intervals, directed and then random, with random idle cycles
// and result stalls. Each result is checked against the count given with a
// directed set, or else against a sort-and-sweep predictor kept in the bench.
// ----------------------------------------------------------------------------
module interval_min_resources_test;
  import imr_pkg::*;

  localparam int DEPTH      = MAX_INTERVALS_DEF;
  localparam int IDLE_LIMIT = 250000;

  typedef struct {
    item_t   it;
    bit      typed;
    result_t want;
  } row_t;

  logic    clk;
  logic    rst;
  logic    item_valid;
  logic    item_stall;
  item_t   item;
  logic    result_valid;
  logic    result_stall;
  result_t result;

  // calm turns off all idling on both sides
  bit      calm;
  int      fails;
  int      items_sent;
  int      counts_seen;
  int      idle_cycles;
  result_t counts_due[$];
  row_t    plan[$];

  // intervals of the set now being loaded
  int      set_starts[$];
  int      set_ends[$];
  bit      set_dropped;
  int      sorted_starts[DEPTH];
  int      sorted_ends[DEPTH];

  interval_min_resources u_dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // sort ascending in place
  function automatic void sort_times(ref int a[DEPTH], input int n);
    int key;
    int k;
    for (int i = 1; i < n; i++) begin
      key = a[i];
      k = i;
      while (k > 0 && a[k-1] > key) begin
        a[k] = a[k-1];
        k--;
      end
      a[k] = key;
    end
  endfunction

  // store one interval; on the last one compute the resource count
  function automatic result_t count_resources(item_t it);
    result_t r;
    int n;
    int j;
    int cnt;
    r = '0;
    if (set_starts.size() < DEPTH) begin
      set_starts = {set_starts, int'(it.start_time)};
      set_ends = {set_ends, int'(it.end_time)};
    end else begin
      set_dropped = 1'b1;
    end
    if (!it.last_interval) return r;
    n = set_starts.size();
    for (int i = 0; i < n; i++) begin
      sorted_starts[i] = set_starts[i];
      sorted_ends[i] = set_ends[i];
    end
    sort_times(sorted_starts, n);
    sort_times(sorted_ends, n);
    j = 0;
    cnt = 0;
    for (int i = 0; i < n; i++) begin
      if (sorted_starts[i] >= sorted_ends[j]) j++;
      else cnt++;
    end
    r.resource_count = cnt[COUNT_W-1:0];
    r.overflowed = set_dropped;
    return r;
  endfunction

  // one transfer on the interval side, with random idle cycles before it
  task automatic send(item_t it, bit typed = 1'b0, result_t want = '0);
    result_t r;
    while (!calm && $urandom_range(0, 99) < 25) begin
      item_valid = 1'b0;
      @(negedge clk);
    end
    item_valid = 1'b1;
    item = it;
    do @(posedge clk); while (item_stall);
    items_sent++;
    if (it.last_interval) begin
      r = count_resources(it);
      counts_due = {counts_due, (typed ? want : r)};
      set_starts.delete();
      set_ends.delete();
      set_dropped = 1'b0;
    end else begin
      void'(count_resources(it));
    end
    @(negedge clk);
  endtask

  function automatic void add(logic signed [TIME_W-1:0] s, logic signed [TIME_W-1:0] e,
                              bit l, bit typed = 1'b0, int cnt = 0, bit ov = 1'b0);
    row_t r;
    r.it = '{start_time: s, end_time: e, last_interval: l};
    r.typed = typed;
    r.want = '{resource_count: cnt[COUNT_W-1:0], overflowed: ov};
    plan = {plan, r};
  endfunction

  function automatic item_t random_interval(bit l);
    item_t it;
    int base;
    base = $urandom_range(0, 300);
    case ($urandom_range(0, 4))
      0: begin
        it.start_time = $urandom;
        it.end_time = $urandom;
      end
      1: begin
        it.start_time = -base;
        it.end_time = -base + $urandom_range(0, 80);
      end
      2: begin
        it.start_time = base + 10;
        it.end_time = base + 10 - $urandom_range(0, 10);
      end
      default: begin
        it.start_time = base;
        it.end_time = base + $urandom_range(0, 80);
      end
    endcase
    it.last_interval = l;
    return it;
  endfunction

  // result side stalls
  always @(negedge clk) begin
    result_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 25);
  end

  // result check
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      counts_seen++;
      if (counts_due.size() == 0) begin
        $error("result with no set pending: resource_count %0d", result.resource_count);
        fails++;
      end else begin
        if (result.resource_count !== counts_due[0].resource_count) begin
          $error("resource_count expected %0d actual %0d",
                 counts_due[0].resource_count, result.resource_count);
          fails++;
        end
        if (result.overflowed !== counts_due[0].overflowed) begin
          $error("overflowed expected %0b actual %0b",
                 counts_due[0].overflowed, result.overflowed);
          fails++;
        end
        void'(counts_due.pop_front());
      end
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("interval_min_resources: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int set_len;
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    result_stall = 1'b0;
    calm = 1'b0;
    fails = 0;
    items_sent = 0;
    counts_seen = 0;
    idle_cycles = 0;
    set_dropped = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed sets
    add(0, 10, 1, 1, 1);
    add(32'sh8000_0000, 32'sh7fff_ffff, 1, 1, 1);
    // end before start reuses at once
    add(32'sh7fff_ffff, 32'sh8000_0000, 1, 1, 0);
    add(0, 5, 0);
    add(0, 5, 1, 1, 2);
    // touching intervals share one resource
    add(0, 5, 0);
    add(5, 10, 1, 1, 1);
    add(0, 100, 0);
    add(10, 20, 0);
    add(30, 40, 1);
    add(-1, -1, 0);
    add(32'sh8000_0000, 0, 1);
    add(32'sh5555_5555, 32'shaaaa_aaaa, 0);
    add(32'shaaaa_aaaa, 32'sh5555_5555, 0);
    add(32'sh7fff_fffe, 32'sh7fff_ffff, 1);
    foreach (plan[i]) send(plan[i].it, plan[i].typed, plan[i].want);

    // hold the sender until every count is back
    item_valid = 1'b0;
    while (counts_due.size() != 0) @(negedge clk);

    // random sets, mostly small, with a calm stretch
    while (items_sent < 750) begin
      calm = (items_sent > 350 && items_sent < 500);
      set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
      for (int i = 0; i < set_len; i++) send(random_interval(i == set_len - 1));
    end
    calm = 1'b0;
    item_valid = 1'b0;

    while (counts_due.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("sent %0d intervals, checked %0d resource counts", items_sent, counts_seen);
    $display("covered extremes, reversed intervals, touching ends and random sets");
    if (fails == 0) begin
      $display("interval_min_resources: match");
    end else begin
      $display("interval_min_resources: mismatch");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/imr_pkg.sv
rtl/core/imr_merge_pick.sv
rtl/core/interval_min_resources.sv
test/interval_min_resources_test.sv
